// ----- design/rss_pkg.sv -----
// ---------------------------------------------------------------------------
// rss_pkg
// shared constants, register codes and config struct for the inverse
// rotate/scale source address generator
// ---------------------------------------------------------------------------
package rss_pkg;

	// fixed point fraction bits of cosine, sine and inverse scales
	localparam int FRAC_BITS = 10;

	// both fraction shifts (scale step and pixel floor) folded into one
	localparam int SHIFT_W   = 2 * FRAC_BITS;

	localparam int COORD_IN_W = 16;
	localparam int DIFF_W     = COORD_IN_W + 1;       // screen minus pivot
	localparam int TRIG_W     = 12;
	localparam int SCALE_IN_W = 21;
	localparam int SCALE_W    = SCALE_IN_W + 1;       // scale as signed operand
	localparam int PR1_W      = TRIG_W + DIFF_W;      // one rotation product
	localparam int ROT_W      = PR1_W + 1;            // rotated offset
	localparam int PROD_W     = ROT_W + SCALE_W;      // scaled offset
	localparam int COORD_W    = PROD_W - SHIFT_W + 1; // source pixel, full width
	localparam int BPP_W      = 3;
	localparam int WORD_W     = 32;

	localparam int CFG_IDX_W  = 3;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROT_COS      = 3'd0,
		REG_ROT_SIN      = 3'd1,
		REG_XSCALE_RECIP = 3'd2,
		REG_YSCALE_RECIP = 3'd3,
		REG_IMAGE_PIVOT  = 3'd4,
		REG_SCR_PIVOT    = 3'd5,
		REG_IMAGE_SIZE   = 3'd6,
		REG_BYTES_PP     = 3'd7
	} cfg_index_t;

	// reset values
	localparam logic [TRIG_W-1:0]     ROT_COS_RST     = 12'd1024;
	localparam logic [TRIG_W-1:0]     ROT_SIN_RST     = 12'd0;
	localparam logic [SCALE_IN_W-1:0] INV_SCALE_RST   = 21'd1024;
	localparam logic [WORD_W-1:0]     PIVOT_RST       = 32'd0;
	localparam logic [WORD_W-1:0]     IMAGE_SIZE_RST  = 32'd65537;
	localparam logic [BPP_W-1:0]      BYTES_PP_RST    = 3'd2;

	typedef struct packed {
		logic [TRIG_W-1:0]     rot_cos;
		logic [TRIG_W-1:0]     rot_sin;
		logic [SCALE_IN_W-1:0] xscale_recip;
		logic [SCALE_IN_W-1:0] yscale_recip;
		logic [WORD_W-1:0]     image_pivot;
		logic [WORD_W-1:0]     scr_pivot;
		logic [WORD_W-1:0]     image_size;
		logic [BPP_W-1:0]      bytes_per_pixel;
	} cfg_t;

endpackage

// ----- design/rss_cfg.sv -----
// ---------------------------------------------------------------------------
// rss_cfg
// configuration register file, written one register per beat
// ---------------------------------------------------------------------------
module rss_cfg
	import rss_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot_cos         <= ROT_COS_RST;
			cfg_q.rot_sin         <= ROT_SIN_RST;
			cfg_q.xscale_recip    <= INV_SCALE_RST;
			cfg_q.yscale_recip    <= INV_SCALE_RST;
			cfg_q.image_pivot     <= PIVOT_RST;
			cfg_q.scr_pivot       <= PIVOT_RST;
			cfg_q.image_size      <= IMAGE_SIZE_RST;
			cfg_q.bytes_per_pixel <= BYTES_PP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				REG_ROT_COS:      cfg_q.rot_cos         <= cfg_data[TRIG_W-1:0];
				REG_ROT_SIN:      cfg_q.rot_sin         <= cfg_data[TRIG_W-1:0];
				REG_XSCALE_RECIP: cfg_q.xscale_recip    <= cfg_data[SCALE_IN_W-1:0];
				REG_YSCALE_RECIP: cfg_q.yscale_recip    <= cfg_data[SCALE_IN_W-1:0];
				REG_IMAGE_PIVOT:  cfg_q.image_pivot     <= cfg_data;
				REG_SCR_PIVOT:    cfg_q.scr_pivot       <= cfg_data;
				REG_IMAGE_SIZE:   cfg_q.image_size      <= cfg_data;
				REG_BYTES_PP:     cfg_q.bytes_per_pixel <= cfg_data[BPP_W-1:0];
				default:          cfg_q                 <= cfg_q;
			endcase
		end
	end

endmodule

// ----- design/rotate_scale_source_address_top.sv -----
// ---------------------------------------------------------------------------
// rotate_scale_source_address_top
// inverse rotate/scale source address generator, nearest neighbor
// ---------------------------------------------------------------------------
// throughput: one beat per cycle while the output is not stalled, through the
//   eight-stage pipeline; the multipliers sit in stages s2, s4, s7 and s8
// reset: arst_n clears all stage valid bits and loads register reset values
// stalls: each stage takes a new beat when empty or when the next one moves
// ---------------------------------------------------------------------------
module rotate_scale_source_address_top
	import rss_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,

	// screen pixel in
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [31:0]          s_axis_tdata,  // screen_x[15:0], screen_y[31:16]

	// source address out
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [63:0]          m_axis_tdata,  // source_col[15:0], source_row[31:16],
	                                            // byte_offset[63:32]
	output logic                 m_axis_tuser   // inside_res
);

	localparam logic signed [15:0] SAT_MAX = 16'sh7fff;
	localparam logic signed [15:0] SAT_MIN = -16'sh8000;

	cfg_t cfg;

	rss_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// unpacked config views
	logic signed [TRIG_W-1:0]     rot_cos, rot_sin;
	logic signed [COORD_IN_W-1:0] spx, spy, ipx, ipy;
	logic [15:0]                  img_w, img_h;

	assign rot_cos = $signed(cfg.rot_cos);
	assign rot_sin = $signed(cfg.rot_sin);
	assign spx     = $signed(cfg.scr_pivot[15:0]);
	assign spy     = $signed(cfg.scr_pivot[31:16]);
	assign ipx     = $signed(cfg.image_pivot[15:0]);
	assign ipy     = $signed(cfg.image_pivot[31:16]);
	assign img_w   = cfg.image_size[15:0];
	assign img_h   = cfg.image_size[31:16];

	// stage valids and advance enables
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8;

	// a stage moves when it is empty or its successor moves
	assign en_s8 = !valid_s8 || m_axis_tready;
	assign en_s7 = !valid_s7 || en_s8;
	assign en_s6 = !valid_s6 || en_s7;
	assign en_s5 = !valid_s5 || en_s6;
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;

	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= s_axis_tvalid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
			if (en_s6) valid_s6 <= valid_s5;
			if (en_s7) valid_s7 <= valid_s6;
			if (en_s8) valid_s8 <= valid_s7;
		end
	end

	// s1: offset from screen pivot, in whole pixels (the fraction scaling
	// cancels against the first floor, so rotation stays exact)
	logic signed [COORD_IN_W-1:0] screen_x, screen_y;
	logic signed [DIFF_W-1:0]     dx_s1, dy_s1;

	assign screen_x = $signed(s_axis_tdata[15:0]);
	assign screen_y = $signed(s_axis_tdata[31:16]);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			dx_s1 <= DIFF_W'(screen_x) - DIFF_W'(spx);
			dy_s1 <= DIFF_W'(screen_y) - DIFF_W'(spy);
		end
	end

	// s2: four rotation products
	logic signed [PR1_W-1:0] cdx_s2, sdy_s2, cdy_s2, sdx_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			cdx_s2 <= PR1_W'(rot_cos) * PR1_W'(dx_s1);
			sdy_s2 <= PR1_W'(rot_sin) * PR1_W'(dy_s1);
			cdy_s2 <= PR1_W'(rot_cos) * PR1_W'(dy_s1);
			sdx_s2 <= PR1_W'(rot_sin) * PR1_W'(dx_s1);
		end
	end

	// s3: rotate back
	logic signed [ROT_W-1:0] rot_x_s3, rot_y_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			rot_x_s3 <= ROT_W'(cdx_s2) + ROT_W'(sdy_s2);
			rot_y_s3 <= ROT_W'(cdy_s2) - ROT_W'(sdx_s2);
		end
	end

	// s4: inverse scale
	logic signed [SCALE_W-1:0] scale_x, scale_y;
	logic signed [PROD_W-1:0]  prod_x_s4, prod_y_s4;

	assign scale_x = $signed({1'b0, cfg.xscale_recip});
	assign scale_y = $signed({1'b0, cfg.yscale_recip});

	always_ff @(posedge clk) begin
		if (en_s4) begin
			prod_x_s4 <= PROD_W'(rot_x_s3) * PROD_W'(scale_x);
			prod_y_s4 <= PROD_W'(rot_y_s3) * PROD_W'(scale_y);
		end
	end

	// s5: both floors as one arithmetic shift, then add image pivot
	logic signed [PROD_W-1:0]  shr_x, shr_y;
	logic signed [COORD_W-1:0] col_s5, row_s5;

	assign shr_x = prod_x_s4 >>> SHIFT_W;
	assign shr_y = prod_y_s4 >>> SHIFT_W;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			col_s5 <= COORD_W'(shr_x) + COORD_W'(ipx);
			row_s5 <= COORD_W'(shr_y) + COORD_W'(ipy);
		end
	end

	// s6: bounds test on full-width coordinates, saturate for output
	logic                    in_image;
	logic                    col_fits, row_fits;
	logic signed [15:0]      col_sat, row_sat;
	logic                    in_image_s6;
	logic [15:0]             col_sat_s6, row_sat_s6, col_lo_s6, row_lo_s6;

	assign in_image = !col_s5[COORD_W-1] && !row_s5[COORD_W-1]
		&& (col_s5[COORD_W-2:0] < (COORD_W-1)'(img_w))
		&& (row_s5[COORD_W-2:0] < (COORD_W-1)'(img_h));

	// fits in 16 bits when all bits from bit 15 up agree
	assign col_fits = (col_s5[COORD_W-1:15] == '0) || (col_s5[COORD_W-1:15] == '1);
	assign row_fits = (row_s5[COORD_W-1:15] == '0) || (row_s5[COORD_W-1:15] == '1);

	always_comb begin
		if (col_fits) col_sat = col_s5[15:0];
		else if (col_s5[COORD_W-1]) col_sat = SAT_MIN;
		else col_sat = SAT_MAX;
		if (row_fits) row_sat = row_s5[15:0];
		else if (row_s5[COORD_W-1]) row_sat = SAT_MIN;
		else row_sat = SAT_MAX;
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			in_image_s6 <= in_image;
			col_sat_s6  <= col_sat;
			row_sat_s6  <= row_sat;
			col_lo_s6   <= col_s5[15:0];
			row_lo_s6   <= row_s5[15:0];
		end
	end

	// s7: row times width
	logic        in_image_s7;
	logic [15:0] col_sat_s7, row_sat_s7, col_lo_s7;
	logic [31:0] row_w_s7;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			in_image_s7 <= in_image_s6;
			col_sat_s7  <= col_sat_s6;
			row_sat_s7  <= row_sat_s6;
			col_lo_s7   <= col_lo_s6;
			row_w_s7    <= {16'b0, row_lo_s6} * {16'b0, img_w};
		end
	end

	// s8: add column, times bytes per pixel, wraps at 32 bits, zero when outside; output register
	logic [WORD_W-1:0]       pix_index;
	logic [WORD_W+BPP_W-1:0] off_full;
	logic                    in_image_s8;
	logic [15:0]             col_sat_s8, row_sat_s8;
	logic [WORD_W-1:0]       offset_s8;

	assign pix_index = row_w_s7 + {16'b0, col_lo_s7};
	assign off_full  = {{BPP_W{1'b0}}, pix_index} * {{WORD_W{1'b0}}, cfg.bytes_per_pixel};

	always_ff @(posedge clk) begin
		if (en_s8) begin
			in_image_s8 <= in_image_s7;
			col_sat_s8  <= col_sat_s7;
			row_sat_s8  <= row_sat_s7;
			offset_s8   <= in_image_s7 ? off_full[WORD_W-1:0] : '0;
		end
	end

	assign m_axis_tvalid = valid_s8;
	assign m_axis_tdata  = {offset_s8, row_sat_s8, col_sat_s8};
	assign m_axis_tuser  = in_image_s8;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// checks the inverse rotate/scale source address generator: a directed list
// of pixels and register writes, then random phases that each load a fresh
// register set and stream pixels, most with random gaps and output stalls.
// every output beat is checked field by field against a hand-written result
// or a predictor in this file
module testbench;
	import rss_pkg::*;

	localparam int PHASES          = 14;
	localparam int ITEMS_PER_PHASE = 75;
	localparam int PIPE_LAT        = 8;     // input beat to output beat, per the top level
	localparam int STALL_LIMIT     = 4000;  // cycles with no beat on any channel
	localparam int REPORT_MAX      = 10;

	// one output beat: inside flag, saturated column and row, byte offset
	typedef struct packed {
		logic        inside_res;
		logic [15:0] source_col;
		logic [15:0] source_row;
		logic [31:0] byte_offset;
	} src_addr_t;

	// a step of the directed list: either a pixel or a register write
	typedef enum bit {ROW_PIXEL, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		cfg_index_t  idx;
		logic [31:0] data;
		logic [15:0] x;
		logic [15:0] y;
		bit          typed;   // want holds a hand-written result
		src_addr_t   want;
	} plan_row_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	cfg_index_t        cfg_index     = REG_ROT_COS;
	logic [WORD_W-1:0] cfg_data      = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [31:0]       s_axis_tdata  = '0;  // screen_x[15:0], screen_y[31:16]
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [63:0]       m_axis_tdata;        // source_col[15:0], source_row[31:16],
	                                        // byte_offset[63:32]
	logic              m_axis_tuser;        // inside_res

	// register copy that the predictor works from, updated on each config beat
	cfg_t        shadow;
	// predicted beats, oldest first
	src_addr_t   pending_addr[$];
	plan_row_t   plan[$];
	int          miss_count = 0;
	bit          quiet      = 1'b0;   // no gaps and no stalls while set
	int          stall_left = 0;

	always #6 clk = ~clk;

	rotate_scale_source_address_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// clamp to the 16-bit signed output range
	function automatic logic [15:0] clamp16(input longint v);
		longint c;
		c = v;
		if (c > 32767)
			c = 32767;
		if (c < -32768)
			c = -32768;
		return c[15:0];
	endfunction

	// maps one screen pixel back to its source pixel under the current registers;
	// everything is held in 64 bits so no step wraps, and >>> floors
	function automatic src_addr_t map_pixel(input logic [15:0] x, input logic [15:0] y);
		longint rel_x, rel_y, rot_x, rot_y, fix_x, fix_y, col, row, w, h;
		longint cs, sn;
		src_addr_t r;
		cs    = longint'($signed(shadow.rot_cos));
		sn    = longint'($signed(shadow.rot_sin));
		w     = longint'(shadow.image_size[15:0]);
		h     = longint'(shadow.image_size[31:16]);
		rel_x = (longint'($signed(x)) - longint'($signed(shadow.scr_pivot[15:0])))
			<<< FRAC_BITS;
		rel_y = (longint'($signed(y)) - longint'($signed(shadow.scr_pivot[31:16])))
			<<< FRAC_BITS;
		// rotate back: transpose of the forward rotation
		rot_x = (cs * rel_x + sn * rel_y) >>> FRAC_BITS;
		rot_y = (cs * rel_y - sn * rel_x) >>> FRAC_BITS;
		fix_x = ((rot_x * longint'(shadow.xscale_recip)) >>> FRAC_BITS)
			+ (longint'($signed(shadow.image_pivot[15:0])) <<< FRAC_BITS);
		fix_y = ((rot_y * longint'(shadow.yscale_recip)) >>> FRAC_BITS)
			+ (longint'($signed(shadow.image_pivot[31:16])) <<< FRAC_BITS);
		col   = fix_x >>> FRAC_BITS;
		row   = fix_y >>> FRAC_BITS;
		// the inside test uses the full-width coordinates, not the clamped ones
		r.inside_res  = (col >= 0) && (col < w) && (row >= 0) && (row < h);
		r.source_col  = clamp16(col);
		r.source_row  = clamp16(row);
		r.byte_offset = '0;
		if (r.inside_res) begin
			longint off;
			off = (row * w + col) * longint'(shadow.bytes_per_pixel);
			r.byte_offset = off[31:0];
		end
		return r;
	endfunction

	function automatic plan_row_t pix(input logic [15:0] x, input logic [15:0] y);
		plan_row_t p;
		p = '{kind: ROW_PIXEL, idx: REG_ROT_COS, data: '0, x: x, y: y, typed: 1'b0,
			want: '0};
		return p;
	endfunction

	function automatic plan_row_t pix_known(input logic [15:0] x, input logic [15:0] y,
			input src_addr_t want);
		plan_row_t p;
		p       = pix(x, y);
		p.typed = 1'b1;
		p.want  = want;
		return p;
	endfunction

	function automatic plan_row_t reg_row(input cfg_index_t idx, input logic [31:0] data);
		plan_row_t p;
		p      = pix('0, '0);
		p.kind = ROW_WRITE;
		p.idx  = idx;
		p.data = data;
		return p;
	endfunction

	// one config beat; cfg_valid is left high so back-to-back writes need no
	// lower/raise in the same step, the next pixel beat drops it
	task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ROT_COS:      shadow.rot_cos         = data[TRIG_W-1:0];
			REG_ROT_SIN:      shadow.rot_sin         = data[TRIG_W-1:0];
			REG_XSCALE_RECIP: shadow.xscale_recip    = data[SCALE_IN_W-1:0];
			REG_YSCALE_RECIP: shadow.yscale_recip    = data[SCALE_IN_W-1:0];
			REG_IMAGE_PIVOT:  shadow.image_pivot     = data;
			REG_SCR_PIVOT:    shadow.scr_pivot       = data;
			REG_IMAGE_SIZE:   shadow.image_size      = data;
			REG_BYTES_PP:     shadow.bytes_per_pixel = data[BPP_W-1:0];
			default: ;
		endcase
	endtask

	// one pixel beat, with a random gap ahead of it unless quiet
	task automatic send_pixel(input logic [15:0] x, input logic [15:0] y, input bit typed,
			input src_addr_t want);
		int gap;
		cfg_valid <= 1'b0;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 11);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {y, x};
		do @(posedge clk); while (!s_axis_tready);
		pending_addr.push_back(typed ? want : map_pixel(x, y));
	endtask

	// hold the input until every predicted beat is out, then let the pipe settle
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_addr.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	// output side: compare each beat with the oldest prediction, then pick the
	// ready level for the next cycle, with random stall bursts unless quiet
	always @(posedge clk) begin
		src_addr_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[63:32]};
			if (pending_addr.size() == 0) begin
				miss_count++;
				if (miss_count <= REPORT_MAX)
					$display("unexpected output beat: tuser=%b tdata=%h", m_axis_tuser,
						m_axis_tdata);
			end else begin
				want = pending_addr.pop_front();
				if (got.inside_res !== want.inside_res || got.source_col !== want.source_col
						|| got.source_row !== want.source_row
						|| got.byte_offset !== want.byte_offset) begin
					miss_count++;
					if (miss_count <= REPORT_MAX)
						$display("mismatch: want in=%b col=%0d row=%0d off=%h, got in=%b col=%0d row=%0d off=%h",
							want.inside_res, $signed(want.source_col), $signed(want.source_row),
							want.byte_offset, got.inside_res, $signed(got.source_col),
							$signed(got.source_row), got.byte_offset);
				end
			end
		end
		if (quiet) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 11) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// watchdog: ends the run once no channel has moved a beat for too long
	initial begin : watchdog
		int still;
		still = 0;
		@(posedge arst_n);
		while (still < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				still = 0;
			else
				still++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] word;
		logic [15:0] px, py;
		int          tmp, pause_at;
		bit          wide;

		shadow = '{rot_cos: ROT_COS_RST, rot_sin: ROT_SIN_RST, xscale_recip: INV_SCALE_RST,
			yscale_recip: INV_SCALE_RST, image_pivot: PIVOT_RST, scr_pivot: PIVOT_RST,
			image_size: IMAGE_SIZE_RST, bytes_per_pixel: BYTES_PP_RST};

		// reset values: identity map onto a 1x1 image, 2 bytes per pixel
		plan.push_back(pix_known(16'd0, 16'd0, '{1'b1, 16'd0, 16'd0, 32'd0}));
		plan.push_back(pix_known(16'd1, 16'd0, '{1'b0, 16'd1, 16'd0, 32'd0}));
		plan.push_back(pix_known(16'hFFFF, 16'hFFFF, '{1'b0, 16'hFFFF, 16'hFFFF, 32'd0}));
		plan.push_back(pix_known(16'h7FFF, 16'h8000, '{1'b0, 16'h7FFF, 16'h8000, 32'd0}));
		plan.push_back(pix_known(16'h8000, 16'h7FFF, '{1'b0, 16'h8000, 16'h7FFF, 32'd0}));
		// largest image, 4 bytes per pixel: the far corner overflows the offset
		plan.push_back(reg_row(REG_IMAGE_SIZE, 32'hFFFF_FFFF));
		plan.push_back(reg_row(REG_BYTES_PP, 32'd4));
		plan.push_back(pix_known(16'h7FFF, 16'h7FFF, '{1'b1, 16'h7FFF, 16'h7FFF, 32'hFFFC_0000}));
		// largest inverse scale: source coordinates run past 16 bits and clamp
		plan.push_back(reg_row(REG_XSCALE_RECIP, 32'h001F_FFFF));
		plan.push_back(reg_row(REG_YSCALE_RECIP, 32'h001F_FFFF));
		plan.push_back(pix(16'h7FFF, 16'h8000));
		plan.push_back(pix(16'd100, 16'd5));
		// zero inverse scale: everything lands on the image pivot (7, 3)
		plan.push_back(reg_row(REG_XSCALE_RECIP, 32'd0));
		plan.push_back(reg_row(REG_YSCALE_RECIP, 32'd0));
		plan.push_back(reg_row(REG_IMAGE_PIVOT, 32'h0003_0007));
		plan.push_back(pix_known(16'h8000, 16'h8000, '{1'b1, 16'd7, 16'd3, 32'd786448}));
		plan.push_back(pix_known(16'd12345, 16'hF752, '{1'b1, 16'd7, 16'd3, 32'd786448}));
		// zero bytes per pixel gives offset zero even inside
		plan.push_back(reg_row(REG_BYTES_PP, 32'd0));
		plan.push_back(pix_known(16'd1, 16'd1, '{1'b1, 16'd7, 16'd3, 32'd0}));
		// zero width and height: nothing is inside
		plan.push_back(reg_row(REG_IMAGE_SIZE, 32'd0));
		plan.push_back(pix_known(16'd0, 16'd0, '{1'b0, 16'd7, 16'd3, 32'd0}));
		// quarter turn on a 16x16 image with both pivots moved
		plan.push_back(reg_row(REG_ROT_COS, 32'd0));
		plan.push_back(reg_row(REG_ROT_SIN, 32'd1024));
		plan.push_back(reg_row(REG_XSCALE_RECIP, 32'd1024));
		plan.push_back(reg_row(REG_YSCALE_RECIP, 32'd1024));
		plan.push_back(reg_row(REG_IMAGE_PIVOT, 32'h0008_0008));
		plan.push_back(reg_row(REG_IMAGE_SIZE, 32'h0010_0010));
		plan.push_back(reg_row(REG_BYTES_PP, 32'd3));
		plan.push_back(reg_row(REG_SCR_PIVOT, 32'hFFFB_0005));
		plan.push_back(pix(16'd3, 16'd4));
		plan.push_back(pix(16'hFFF9, 16'd2));
		// most negative cosine, largest sine, pivots at opposite corners
		plan.push_back(reg_row(REG_ROT_COS, 32'h0000_0800));
		plan.push_back(reg_row(REG_ROT_SIN, 32'h0000_07FF));
		plan.push_back(reg_row(REG_SCR_PIVOT, 32'h8000_7FFF));
		plan.push_back(reg_row(REG_IMAGE_PIVOT, 32'h7FFF_8000));
		plan.push_back(pix(16'h8000, 16'h7FFF));
		plan.push_back(pix(16'h7FFF, 16'h8000));
		plan.push_back(pix(16'd0, 16'd0));
		plan.push_back(reg_row(REG_ROT_COS, 32'h0000_07FF));
		plan.push_back(reg_row(REG_ROT_SIN, 32'h0000_0800));
		plan.push_back(pix(16'h8000, 16'h8000));
		plan.push_back(pix(16'h7FFF, 16'h7FFF));

		// reset held low, released on a rising edge
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed list; registers change only once the pipe is empty
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				if (i > 0 && plan[i-1].kind == ROW_PIXEL)
					drain_results();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_pixel(plan[i].x, plan[i].y, plan[i].typed, plan[i].want);
			end
		end

		// random phases: fresh registers each time, mostly sane with some extremes
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			quiet = (ph >= PHASES - 2) || ($urandom_range(0, 4) == 0);
			for (int r = 0; r < 8; r++) begin
				word = $urandom;   // junk in the unused upper bits
				wide = ($urandom_range(0, 4) == 0);
				case (cfg_index_t'(r))
					REG_ROT_COS, REG_ROT_SIN: begin
						if (wide) begin
							case ($urandom_range(0, 4))
								0: tmp = -2048;
								1: tmp = 2047;
								2: tmp = -1024;
								3: tmp = 1024;
								default: tmp = 0;
							endcase
						end else begin
							tmp = int'($urandom_range(0, 2048)) - 1024;
						end
						word[11:0] = tmp[11:0];
					end
					REG_XSCALE_RECIP, REG_YSCALE_RECIP: begin
						if (wide) begin
							case ($urandom_range(0, 4))
								0: tmp = 0;
								1: tmp = 1;
								2: tmp = 1048576;
								3: tmp = 21'h1F_FFFF;
								default: tmp = $urandom_range(0, 21'h1F_FFFF);
							endcase
						end else begin
							tmp = $urandom_range(128, 4096);
						end
						word[20:0] = tmp[20:0];
					end
					REG_IMAGE_PIVOT: begin
						if (!wide)
							word = {16'($urandom_range(0, 128)), 16'($urandom_range(0, 128))};
					end
					REG_SCR_PIVOT: begin
						if (!wide)
							word = {16'($urandom_range(0, 480)), 16'($urandom_range(0, 640))};
					end
					REG_IMAGE_SIZE: begin
						if (wide) begin
							case ($urandom_range(0, 3))
								0: word[15:0] = '0;
								1: word[31:16] = '0;
								2: word = 32'hFFFF_FFFF;
								default: ;
							endcase
						end else begin
							word = {16'($urandom_range(1, 256)), 16'($urandom_range(1, 256))};
						end
					end
					default: begin
						if (!wide)
							word[2:0] = 3'($urandom_range(1, 4));
					end
				endcase
				write_reg(cfg_index_t'(r), word);
			end
			// once per phase the sender waits for the output to empty mid-stream
			pause_at = $urandom_range(1, ITEMS_PER_PHASE - 1);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == pause_at)
					drain_results();
				if ($urandom_range(0, 3) == 0) begin
					word = $urandom;
					px = word[15:0];
					py = word[31:16];
				end else begin
					// near the screen pivot, so many pixels land inside the image
					tmp = int'($signed(shadow.scr_pivot[15:0]))
						+ int'($urandom_range(0, 600)) - 300;
					px = tmp[15:0];
					tmp = int'($signed(shadow.scr_pivot[31:16]))
						+ int'($urandom_range(0, 600)) - 300;
					py = tmp[15:0];
				end
				send_pixel(px, py, 1'b0, '0);
			end
		end

		drain_results();
		if (miss_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
